/* rtl/core/sbpe_pkg.sv */
// ----------------------------------------------------------------------------
// sbpe_pkg
// Shared types and constants of the servo bus packet encoder.
// ----------------------------------------------------------------------------
package sbpe_pkg;

  localparam int unsigned PAYLOAD_BYTES = 4;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [15:0] CRC_POLY = 16'h8005;

  localparam logic [7:0] HDR_SYNC     = 8'hFF;
  localparam logic [7:0] HDR_MARK     = 8'hFD;
  localparam logic [7:0] HDR_RESERVED = 8'h00;
  localparam logic [7:0] LEN_HI       = 8'h00;
  localparam logic [7:0] LEN_READ     = 8'd7;
  localparam logic [7:0] LEN_WR_BASE  = 8'd5;

  localparam logic [7:0] WRITE_OPCODE_RST = 8'd3;
  localparam logic [7:0] READ_OPCODE_RST  = 8'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_OPCODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_OPCODE  = 1'd1;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic clear;
    logic enable;
  } crc_ctrl_t;

endpackage

/* rtl/core/sbpe_crc_unit.sv */
// ----------------------------------------------------------------------------
// sbpe_crc_unit
// CRC-16 accumulator, polynomial 0x8005, not reflected; one byte per cycle.
// ----------------------------------------------------------------------------
module sbpe_crc_unit (
  input  logic              clk,
  input  sbpe_pkg::crc_ctrl_t ctrl,
  input  logic [7:0]        data_byte,
  output logic [15:0]       crc
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [15:0] step;

  always_comb begin
    step = crc_r ^ {data_byte, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (step[15]) begin
        step = {step[14:0], 1'b0} ^ sbpe_pkg::CRC_POLY;
      end else begin
        step = {step[14:0], 1'b0};
      end
    end
  end

  always_comb begin
    priority if (ctrl.clear) begin
      crc_nxt = 16'h0000;
    end else if (ctrl.enable) begin
      crc_nxt = step;
    end else begin
      crc_nxt = crc_r;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign crc = crc_r;

endmodule

/* rtl/core/servo_bus_packet_encoder.sv */
// ----------------------------------------------------------------------------
// servo_bus_packet_encoder
// Builds one servo bus instruction packet per command and sends it a byte
// per cycle, closed by a CRC-16 over all bytes before it.
// ----------------------------------------------------------------------------
//  channel  | handshake          | ports
//  ---------+--------------------+------------------------------------------
//  command  | start & !busy      | in_func in_servo_id in_reg_address
//           |                    | in_byte_count in_payload
//  result   | out_valid strobe   | out_tx_byte out_last
//  config   | cfg_we             | cfg_index cfg_data
//
//  A packet of N bytes (12 to 16) keeps busy high until its final byte shows;
//  the next command is taken in the cycle that byte shows, not before. The
//  byte sequencer and the byte-wide CRC unit set this pacing.
//  Bytes appear in the cycle after they are selected; the receiver cannot stall.
//  Reset returns the sequencer to idle and the opcodes to 3 and 2.
// ----------------------------------------------------------------------------
module servo_bus_packet_encoder #(
  parameter int unsigned MAX_DATA = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_func,
  input  logic [7:0]                     in_servo_id,
  input  logic [15:0]                    in_reg_address,
  input  logic [15:0]                    in_byte_count,
  input  logic [31:0]                    in_payload,
  output logic                           out_valid,
  output logic [7:0]                     out_tx_byte,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [sbpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  localparam int unsigned LIMIT =
    (MAX_DATA > sbpe_pkg::PAYLOAD_BYTES) ? sbpe_pkg::PAYLOAD_BYTES : MAX_DATA;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_BODY   = 4'b0010,
    ST_CRC_LO = 4'b0100,
    ST_CRC_HI = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic        func_r;
  logic [7:0]  id_r;
  logic [15:0] addr_r;
  logic [15:0] cnt_r;
  logic [31:0] payload_r;
  logic [2:0]  dcnt_r;
  logic [2:0]  dcnt_sat;
  logic [7:0]  wr_opcode_r, rd_opcode_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic        accept;
  logic [3:0]  body_last;
  logic [1:0]  data_sel;
  logic [7:0]  len_lo;
  logic [7:0]  body_byte;
  logic [15:0] crc;
  sbpe_pkg::crc_ctrl_t crc_ctrl;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  assign dcnt_sat = (in_byte_count > 16'(LIMIT)) ? 3'(LIMIT) : in_byte_count[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_opcode_r <= sbpe_pkg::WRITE_OPCODE_RST;
      rd_opcode_r <= sbpe_pkg::READ_OPCODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbpe_pkg::CFG_WRITE_OPCODE: wr_opcode_r <= cfg_data;
        sbpe_pkg::CFG_READ_OPCODE:  rd_opcode_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r    <= in_func;
      id_r      <= in_servo_id;
      addr_r    <= in_reg_address;
      cnt_r     <= in_byte_count;
      payload_r <= in_payload;
      dcnt_r    <= dcnt_sat;
    end
  end

  assign body_last = (func_r == sbpe_pkg::FUNC_WRITE) ? (4'd9 + {1'b0, dcnt_r}) : 4'd11;
  assign data_sel  = 2'(idx_r - 4'd10);
  assign len_lo    = (func_r == sbpe_pkg::FUNC_WRITE) ?
                     (sbpe_pkg::LEN_WR_BASE + {5'd0, dcnt_r}) : sbpe_pkg::LEN_READ;

  always_comb begin
    unique case (idx_r)
      4'd0, 4'd1: body_byte = sbpe_pkg::HDR_SYNC;
      4'd2:       body_byte = sbpe_pkg::HDR_MARK;
      4'd3:       body_byte = sbpe_pkg::HDR_RESERVED;
      4'd4:       body_byte = id_r;
      4'd5:       body_byte = len_lo;
      4'd6:       body_byte = sbpe_pkg::LEN_HI;
      4'd7:       body_byte = (func_r == sbpe_pkg::FUNC_WRITE) ? wr_opcode_r : rd_opcode_r;
      4'd8:       body_byte = addr_r[7:0];
      4'd9:       body_byte = addr_r[15:8];
      default: begin
        if (func_r == sbpe_pkg::FUNC_WRITE) begin
          body_byte = payload_r[8*data_sel +: 8];
        end else begin
          body_byte = idx_r[0] ? cnt_r[15:8] : cnt_r[7:0];
        end
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = 1'b0;
    out_byte_nxt   = body_byte;
    out_last_nxt   = 1'b0;
    crc_ctrl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt      = ST_BODY;
          idx_nxt        = 4'd0;
          crc_ctrl.clear = 1'b1;
        end
      end
      ST_BODY: begin
        out_valid_nxt   = 1'b1;
        crc_ctrl.enable = 1'b1;
        idx_nxt         = idx_r + 4'd1;
        if (idx_r == body_last) begin
          state_nxt = ST_CRC_LO;
        end
      end
      ST_CRC_LO: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = crc[7:0];
        state_nxt     = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = crc[15:8];
        out_last_nxt  = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  sbpe_crc_unit u_crc (
    .clk       (clk),
    .ctrl      (crc_ctrl),
    .data_byte (body_byte),
    .crc       (crc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_byte_r;
  assign out_last    = out_last_r;

endmodule

/* rtl/core/sbpe_checker.sv */
// ----------------------------------------------------------------------------
// sbpe_checker
// Port-level checks of the packet encoder, bound to the top level.
// ----------------------------------------------------------------------------
module sbpe_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_last
);

  a_last_is_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("last without strobe");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted item did not start a packet");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !out_valid)
    else $error("byte right after last");

  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_last)
    else $error("packet ended without last byte");

  a_mid_packet_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("byte outside a packet");

endmodule

bind servo_bus_packet_encoder sbpe_checker u_sbpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_last  (out_last)
);
